### src/i2c_slave_register_file_macros.svh
// Assertion macros for the two-wire slave register file.
// Included by every RTL file that carries concurrent assertions; depends on nothing.
`ifndef I2C_SLAVE_REGISTER_FILE_MACROS_SVH
`define I2C_SLAVE_REGISTER_FILE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define I2CSRF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("i2csrf: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define I2CSRF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("i2csrf: next-cycle check failed");

`else

`define I2CSRF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define I2CSRF_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

### src/i2csrf_pkg.sv
// Shared types and constants for the two-wire slave register file.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package i2csrf_pkg;

	localparam int REG_COUNT_DEFAULT = 32;
	localparam int BYTE_W            = 8;

	typedef enum logic [2:0] {
		OP_ADDRESS = 3'd0,
		OP_DATA    = 3'd1,
		OP_STOP    = 3'd2,
		OP_ERROR   = 3'd3,
		OP_LWRITE  = 3'd4,
		OP_LREAD   = 3'd5,
		OP_CLEAR   = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_STARTED = 2'd1,
		PH_POINTER = 2'd2,
		PH_COMM    = 2'd3
	} phase_t;

	typedef struct packed {
		logic [2:0]        opcode;
		logic              master_reads;
		logic [BYTE_W-1:0] bus_byte;
		logic [BYTE_W-1:0] local_index;
		logic [BYTE_W-1:0] local_value;
	} cmd_t;

	typedef struct packed {
		logic              address_ack;
		logic              send_valid;
		logic [BYTE_W-1:0] send_byte;
		logic              aborted;
		logic              new_data;
		logic [1:0]        bus_state;
		logic [BYTE_W-1:0] local_read_byte;
	} rsp_t;

endpackage

### src/i2csrf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the register file storage.
`timescale 1ns / 1ps

module i2csrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### src/i2c_slave_register_file.sv
// Top level of the two-wire slave register file: bus phase machine, pointer and flag.
// Depends on i2csrf_pkg, i2csrf_ram and i2c_slave_register_file_macros.svh.
`timescale 1ns / 1ps
`include "i2c_slave_register_file_macros.svh"

// Takes one bus or local event per transaction on the cmd channel and returns exactly one
// result per event on the rsp channel, in order. A new event can be accepted on every clock
// while cmd_stall is low; the result of an event passes through the registered read of the
// register file RAM and then through the output register. The bus phase, register pointer
// and new-data flag update in the cycle of acceptance, so back-to-back events see each other's
// effects at once. The register file reads as zero after reset without any clearing pass: a
// per-entry written bit, cleared by reset, masks entries that have not been written since.
// cmd_stall rises only when both pipeline stages are full and rsp_stall is high.
module i2c_slave_register_file #(
	parameter int REG_COUNT = i2csrf_pkg::REG_COUNT_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  i2csrf_pkg::cmd_t  cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output i2csrf_pkg::rsp_t  rsp
);

	import i2csrf_pkg::*;

	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam logic [BYTE_W:0] REG_LIMIT = (BYTE_W + 1)'(REG_COUNT);

	// Architectural state.
	phase_t               phase_q, phase_d;
	logic [BYTE_W-1:0]    ptr_q, ptr_d;
	logic                 flag_q, flag_d;
	logic [REG_COUNT-1:0] written_q;

	// Decoded event.
	logic              accept;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic [AW-1:0]     rd_addr;
	logic              rd_hit;
	logic              ack, send, abrt, lread;
	logic              ptr_in_range, lidx_in_range;

	// Stage 1: waits for the RAM read data.
	logic              valid_s1;
	rsp_t              rsp_s1;
	logic              send_s1, lread_s1, hit_s1;
	logic [BYTE_W-1:0] rd_data;
	logic [BYTE_W-1:0] byte_s1;

	// Output register.
	logic              out_valid_q;
	rsp_t              out_q;
	logic              adv_out;

	assign adv_out   = !out_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !adv_out;
	assign accept    = cmd_valid && !cmd_stall;

	assign ptr_in_range  = {1'b0, ptr_q} < REG_LIMIT;
	assign lidx_in_range = {1'b0, cmd.local_index} < REG_LIMIT;

	always_comb begin
		phase_d = phase_q;
		ptr_d   = ptr_q;
		flag_d  = flag_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q[AW-1:0];
		wr_data = cmd.bus_byte;
		rd_addr = ptr_q[AW-1:0];
		ack     = 1'b0;
		send    = 1'b0;
		abrt    = 1'b0;
		lread   = 1'b0;
		case (cmd.opcode)
			OP_ADDRESS: begin
				if (phase_q == PH_IDLE) begin
					phase_d = PH_STARTED;
					ack     = 1'b1;
				end else if (phase_q == PH_POINTER) begin
					ack = 1'b1;
				end else begin
					phase_d = PH_IDLE;
					abrt    = 1'b1;
				end
			end
			OP_DATA: begin
				if (phase_q == PH_STARTED) begin
					ptr_d   = cmd.bus_byte;
					phase_d = PH_POINTER;
				end else if (phase_q inside {PH_POINTER, PH_COMM}) begin
					if (ptr_in_range) begin
						phase_d = PH_COMM;
						if (cmd.master_reads) begin
							send = 1'b1;
						end else begin
							wr_en  = 1'b1;
							flag_d = 1'b1;
						end
						ptr_d = ptr_q + BYTE_W'(1);
					end else begin
						phase_d = PH_IDLE;
						abrt    = 1'b1;
					end
				end
			end
			OP_STOP: begin
				if (phase_q != PH_POINTER) begin
					phase_d = PH_IDLE;
				end
			end
			OP_ERROR: begin
				phase_d = PH_IDLE;
				abrt    = 1'b1;
			end
			OP_LWRITE: begin
				wr_en   = lidx_in_range;
				wr_addr = cmd.local_index[AW-1:0];
				wr_data = cmd.local_value;
			end
			OP_LREAD: begin
				lread   = lidx_in_range;
				rd_addr = cmd.local_index[AW-1:0];
			end
			OP_CLEAR: begin
				flag_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign rd_hit = written_q[rd_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			ptr_q     <= '0;
			flag_q    <= 1'b0;
			written_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			ptr_q   <= ptr_d;
			flag_q  <= flag_d;
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
		end
	end

	i2csrf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (REG_COUNT)
	) u_regs (
		.clk     (clk),
		.wr_en   (accept && wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1.address_ack     <= ack;
			rsp_s1.send_valid      <= send;
			rsp_s1.send_byte       <= '0;
			rsp_s1.aborted         <= abrt;
			rsp_s1.new_data        <= flag_d;
			rsp_s1.bus_state       <= phase_d;
			rsp_s1.local_read_byte <= '0;
			send_s1                <= send;
			lread_s1               <= lread;
			hit_s1                 <= rd_hit;
		end
	end

	// An entry not written since reset reads as zero.
	assign byte_s1 = hit_s1 ? rd_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_q.address_ack     <= rsp_s1.address_ack;
			out_q.send_valid      <= rsp_s1.send_valid;
			out_q.send_byte       <= send_s1 ? byte_s1 : '0;
			out_q.aborted         <= rsp_s1.aborted;
			out_q.new_data        <= rsp_s1.new_data;
			out_q.bus_state       <= rsp_s1.bus_state;
			out_q.local_read_byte <= lread_s1 ? byte_s1 : '0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`I2CSRF_ASSERT_IMP(a_abort_idle, clk, arst_n, rsp_valid && rsp.aborted, rsp.bus_state == PH_IDLE)
	`I2CSRF_ASSERT_IMP(a_ack_state, clk, arst_n, rsp_valid && rsp.address_ack, (rsp.bus_state == PH_STARTED) || (rsp.bus_state == PH_POINTER))
	`I2CSRF_ASSERT_IMP(a_send_comm, clk, arst_n, rsp_valid && rsp.send_valid, rsp.bus_state == PH_COMM)
	`I2CSRF_ASSERT_NXT(a_s1_held, clk, arst_n, valid_s1 && !adv_out, valid_s1 && $stable(rsp_s1))
	`I2CSRF_ASSERT_NXT(a_error_idle, clk, arst_n, accept && (cmd.opcode == OP_ERROR), phase_q == PH_IDLE)

endmodule

### tb/i2c_slave_register_file_tb.sv
// Self-checking testbench for the two-wire slave register file: directed and random events,
// checked against a cycle-free predictor of the bus phase machine, pointer, flag and file.
// Depends on i2csrf_pkg and i2c_slave_register_file; reads no files.
`timescale 1ns / 1ps

module i2c_slave_register_file_tb;
	import i2csrf_pkg::*;

	localparam int REGS = REG_COUNT_DEFAULT;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_REPORTS = 100;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Mirror of the block's state, advanced once per accepted event.
	phase_t bus_phase;
	logic [7:0] reg_ptr;
	logic [7:0] reg_image [REGS];
	logic data_flag;

	rsp_t pending_rsp [$];
	rsp_t oldest;
	int errors = 0;
	int busy_items = 0;
	int sender_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_requests = 0;
	int holds_started = 0;
	int hold_off = 0;
	int quiet_cycles = 0;

	i2c_slave_register_file #(.REG_COUNT(REGS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic rsp_t predict_event(input cmd_t c);
		rsp_t r;
		r = '0;
		case (c.opcode)
		OP_ADDRESS: begin
			if (bus_phase == PH_IDLE) begin
				bus_phase = PH_STARTED;
				r.address_ack = 1'b1;
			end else if (bus_phase == PH_POINTER) begin
				r.address_ack = 1'b1;
			end else begin
				bus_phase = PH_IDLE;
				r.aborted = 1'b1;
			end
		end
		OP_DATA: begin
			if (bus_phase == PH_STARTED) begin
				reg_ptr = c.bus_byte;
				bus_phase = PH_POINTER;
			end else if (bus_phase != PH_IDLE) begin
				if (reg_ptr < REGS) begin
					bus_phase = PH_COMM;
					if (c.master_reads) begin
						r.send_valid = 1'b1;
						r.send_byte = reg_image[reg_ptr];
					end else begin
						reg_image[reg_ptr] = c.bus_byte;
						data_flag = 1'b1;
					end
					reg_ptr = reg_ptr + 8'd1;
				end else begin
					bus_phase = PH_IDLE;
					r.aborted = 1'b1;
				end
			end
		end
		OP_STOP: begin
			if (bus_phase != PH_POINTER)
				bus_phase = PH_IDLE;
		end
		OP_ERROR: begin
			bus_phase = PH_IDLE;
			r.aborted = 1'b1;
		end
		OP_LWRITE: begin
			if (c.local_index < REGS)
				reg_image[c.local_index] = c.local_value;
		end
		OP_LREAD: begin
			if (c.local_index < REGS)
				r.local_read_byte = reg_image[c.local_index];
		end
		OP_CLEAR: begin
			data_flag = 1'b0;
		end
		default: begin
		end
		endcase
		r.new_data = data_flag;
		r.bus_state = bus_phase;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < MAX_REPORTS)
			$display("ERROR %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Offers one event and returns once the block has taken it.
	task automatic send_event(input logic [2:0] op, input logic mr, input logic [7:0] bb,
			input logic [7:0] li, input logic [7:0] lv);
		cmd_t c;
		c.opcode = op;
		c.master_reads = mr;
		c.bus_byte = bb;
		c.local_index = li;
		c.local_value = lv;
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		// Unused opcodes, data while idle and out-of-range local writes do not count towards the random budget.
		if (!(op == OP_UNUSED || (op == OP_DATA && bus_phase == PH_IDLE) ||
				(op == OP_LWRITE && li >= REGS)))
			busy_items++;
		pending_rsp.push_back(predict_event(c));
	endtask

	// Sends an event whose payload fields are all random.
	task automatic send_random_payload(input logic [2:0] op);
		send_event(op, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic random_transfer;
		int r;
		int n;
		logic dir;
		logic [7:0] ptr;
		r = $urandom_range(99);
		if (r < 70) begin
			send_random_payload(OP_ADDRESS);
			if ($urandom_range(99) < 85)
				ptr = 8'($urandom_range(REGS - 1));
			else
				ptr = 8'($urandom);
			send_event(OP_DATA, 1'($urandom), ptr, 8'($urandom), 8'($urandom));
			if ($urandom_range(99) < 30) begin
				send_random_payload(OP_STOP);
				send_random_payload(OP_ADDRESS);
			end
			dir = 1'($urandom);
			n = $urandom_range(1, 8);
			repeat (n) begin
				if ($urandom_range(99) < 10)
					send_event(3'($urandom_range(OP_LWRITE, OP_CLEAR)), 1'($urandom),
						8'($urandom), 8'($urandom_range(REGS - 1)), 8'($urandom));
				send_event(OP_DATA, ($urandom_range(99) < 10) ? ~dir : dir, 8'($urandom),
					8'($urandom), 8'($urandom));
			end
			r = $urandom_range(99);
			if (r < 85)
				send_random_payload(OP_STOP);
			else if (r < 95)
				send_random_payload(OP_ERROR);
			else
				send_random_payload(OP_ADDRESS);
		end else if (r < 88) begin
			send_event(3'($urandom_range(OP_LWRITE, OP_CLEAR)), 1'($urandom), 8'($urandom),
				($urandom_range(99) < 80) ? 8'($urandom_range(REGS - 1)) : 8'($urandom),
				8'($urandom));
		end else begin
			send_random_payload(3'($urandom_range(7)));
		end
	endtask

	task automatic test_local_access;
		send_event(OP_LREAD, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_LREAD, 1'b1, 8'hFF, 8'hFF, 8'hFF);
		send_event(OP_LWRITE, 1'b0, 8'h00, 8'(REGS - 1), 8'hFF);
		send_event(OP_LWRITE, 1'b1, 8'hFF, 8'hFF, 8'h55);
		send_event(OP_LREAD, 1'b0, 8'h00, 8'(REGS - 1), 8'h00);
		send_event(OP_LREAD, 1'b0, 8'h00, 8'(REGS), 8'h00);
		send_event(OP_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF);
	endtask

	task automatic test_bus_phases;
		// Data and stop while idle leave everything as it is.
		send_event(OP_DATA, 1'b0, 8'h12, 8'h00, 8'h00);
		send_event(OP_STOP, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_ADDRESS, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_ADDRESS, 1'b0, 8'h00, 8'h00, 8'h00);
		// The pointer byte is taken even when the direction says read.
		send_event(OP_ADDRESS, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_DATA, 1'b1, 8'(REGS - 2), 8'h00, 8'h00);
		send_event(OP_DATA, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_DATA, 1'b0, 8'hFF, 8'h00, 8'h00);
		send_event(OP_ADDRESS, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_CLEAR, 1'b0, 8'h00, 8'h00, 8'h00);
		// A stop after the pointer byte keeps the pointer for a repeated-start read.
		send_event(OP_ADDRESS, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_DATA, 1'b0, 8'(REGS - 1), 8'h00, 8'h00);
		send_event(OP_STOP, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_ADDRESS, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_DATA, 1'b1, 8'h00, 8'h00, 8'h00);
		send_event(OP_DATA, 1'b1, 8'h00, 8'h00, 8'h00);
		send_event(OP_ADDRESS, 1'b0, 8'h00, 8'h00, 8'h00);
		send_event(OP_DATA, 1'b0, 8'hFF, 8'h00, 8'h00);
		send_event(OP_DATA, 1'b0, 8'hA5, 8'h00, 8'h00);
		send_event(OP_ERROR, 1'b0, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int items);
		int target;
		sender_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		target = busy_items + items;
		while (busy_items < target)
			random_transfer();
	endtask

	// The receiver holds off while events keep coming, so both stages fill and the input stalls.
	task automatic test_backpressure;
		int target;
		sender_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_requests++;
		target = busy_items + 80;
		while (busy_items < target)
			random_transfer();
	endtask

	// A new hold-off request starts a long stretch of stalling, counted down here.
	always @(posedge clk) begin
		if (holds_started != hold_requests) begin
			holds_started <= hold_requests;
			rsp_stall <= 1'b1;
			hold_off <= HOLD_OFF_CYCLES - 1;
		end else if (hold_off > 0) begin
			rsp_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("result with no event outstanding", int'(rsp), 0);
			end else begin
				oldest = pending_rsp.pop_front();
				if (rsp.address_ack !== oldest.address_ack)
					report_mismatch("address_ack", int'(rsp.address_ack),
						int'(oldest.address_ack));
				if (rsp.send_valid !== oldest.send_valid)
					report_mismatch("send_valid", int'(rsp.send_valid),
						int'(oldest.send_valid));
				if (rsp.send_byte !== oldest.send_byte)
					report_mismatch("send_byte", int'(rsp.send_byte),
						int'(oldest.send_byte));
				if (rsp.aborted !== oldest.aborted)
					report_mismatch("aborted", int'(rsp.aborted), int'(oldest.aborted));
				if (rsp.new_data !== oldest.new_data)
					report_mismatch("new_data", int'(rsp.new_data), int'(oldest.new_data));
				if (rsp.bus_state !== oldest.bus_state)
					report_mismatch("bus_state", int'(rsp.bus_state),
						int'(oldest.bus_state));
				if (rsp.local_read_byte !== oldest.local_read_byte)
					report_mismatch("local_read_byte", int'(rsp.local_read_byte),
						int'(oldest.local_read_byte));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL i2c_slave_register_file");
			$finish;
		end
	end

	initial begin
		bus_phase = PH_IDLE;
		reg_ptr = '0;
		data_flag = 1'b0;
		foreach (reg_image[i])
			reg_image[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_local_access();
		test_bus_phases();
		test_random_traffic(0, 0, 430);
		test_random_traffic(69, 0, 430);
		test_random_traffic(0, 69, 430);
		test_random_traffic(22, 22, 430);
		test_backpressure();

		cmd_valid <= 1'b0;
		rsp_stall_pct = 0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS i2c_slave_register_file");
		else
			$display("FAIL i2c_slave_register_file");
		$finish;
	end

endmodule
